// File: sv/wildcard_byte_signature_scanner_core_assert.svh
// Assertion macros for the checker of the signature scanner.
// Depends on nothing; included by the checker module only.
`ifndef WILDCARD_BYTE_SIGNATURE_SCANNER_CORE_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_SCANNER_CORE_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define WBSS_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define WBSS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: sv/wbss_pkg.sv
// Package for the wildcard byte signature scanner: sizes, codes, types
// and the length clamp. Depends on nothing.
package wbss_pkg;

  // Sizing of the signature and address arithmetic.
  localparam int MAX_PATTERN  = 64;
  localparam int ADDRESS_BITS = 32;

  // Fixed field widths of the interface.
  localparam int LEN_REG_W = 7;
  localparam int INDEX_W   = 6;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // Derived sizes: the aligned signature line has 2*MAX_PATTERN-1 slots.
  localparam int ALEN_W    = $clog2(MAX_PATTERN + 1);
  localparam int NUM_SLOTS = 2 * MAX_PATTERN - 1;
  localparam int SLOT_W    = $clog2(2 * MAX_PATTERN);

  // Operation codes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 1'd1;

  // One signature entry: expected byte and care bit.
  typedef struct packed {
    logic       care;
    logic [7:0] value;
  } slot_t;

  // Control broadcast to the signature slot cells.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
  } sig_ctrl_t;

  // One result item.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } result_t;

  // A length of zero acts as one, anything above the maximum as the maximum.
  function automatic logic [ALEN_W-1:0] eff_len(input logic [LEN_REG_W-1:0] raw);
    logic [ALEN_W-1:0] r;
    if (raw == '0) begin
      r = ALEN_W'(1);
    end else if (int'(raw) > MAX_PATTERN) begin
      r = ALEN_W'(MAX_PATTERN);
    end else begin
      r = ALEN_W'(raw);
    end
    return r;
  endfunction

endpackage

// File: sv/wbss_sig_cell.sv
// One slot of the aligned signature line of the scanner.
// Depends on wbss_pkg.
module wbss_sig_cell (
  input  logic              clk_i,
  input  wbss_pkg::sig_ctrl_t ctrl_i,
  input  logic              load_sel_i,
  input  wbss_pkg::slot_t   lower_i,
  input  wbss_pkg::slot_t   upper_i,
  input  wbss_pkg::slot_t   load_i,
  output wbss_pkg::slot_t   slot_o
);

  wbss_pkg::slot_t slot_q, slot_d;

  // A realignment step moves the entry one slot; a load writes it in place.
  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.shift_up) begin
      slot_d = lower_i;
    end else if (ctrl_i.shift_down) begin
      slot_d = upper_i;
    end else if (ctrl_i.load && load_sel_i) begin
      slot_d = load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// File: sv/wbss_win_cell.sv
// One byte of the scan window, with its compare against the aligned
// signature entry. Depends on wbss_pkg.
module wbss_win_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic [7:0]      prev_i,
  input  logic            active_i,
  input  wbss_pkg::slot_t sig_i,
  output logic [7:0]      byte_o,
  output logic            mismatch_o
);

  logic [7:0] byte_q;

  // The window moves by one byte on every accepted memory byte.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= prev_i;
    end
  end

  // The compare sees the byte this cell holds after the shift.
  assign mismatch_o = active_i & sig_i.care & (prev_i != sig_i.value);
  assign byte_o     = byte_q;

endmodule

// File: sv/wbss_out_buf.sv
// Output register with a skid stage for the scanner results.
// Depends on wbss_pkg.
module wbss_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  wbss_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wbss_pkg::result_t out_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  wbss_pkg::result_t out_q, skid_q;
  logic              out_take, load_out, load_skid, out_from_skid;

  assign out_take = out_valid_q & ~out_stall_i;

  // A new result goes to the output register when it is free or being
  // emptied, and into the skid stage otherwise.
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (out_take) begin
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || out_take) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res_i;
    end else if (out_from_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: sv/wildcard_byte_signature_scanner_core.sv
// Top level of the wildcard byte signature scanner.
// Depends on wbss_pkg, wbss_sig_cell, wbss_win_cell and wbss_out_buf.
//
// Use: write pattern_length and base_address on the configuration port, load
// the signature with items of operation 0 (index, byte, care bit), then send
// the memory bytes of a range as items of operation 1, the final one with
// last_byte set. The input channel moves one item per transfer; the output
// channel gives one result for the first match of a range (found 1 and start
// address) or, for a range that ends without a match, one result with found 0
// and address 0. Each result is registered in the output register or, while
// that stays occupied, in the skid stage. Throughput: one item per cycle while
// the input does not stall. The window is a row of byte cells compared in
// parallel against a line of signature slots. After a pattern_length change
// the signature line realigns one slot per cycle while the input stalls.
// When the receiver stalls, one result waits in the output register and a
// second in a skid stage; the input stalls only once both are occupied.
// Reset clears the range state and the result buffer, sets the length to one
// and the base address to zero; the signature must be loaded again.
module wildcard_byte_signature_scanner_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               cfg_we_i,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wbss_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [wbss_pkg::INDEX_W-1:0]       pattern_index_i,
  input  logic [7:0]                         pattern_byte_i,
  input  logic                               pattern_care_i,
  input  logic [7:0]                         data_byte_i,
  input  logic                               last_byte_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic [wbss_pkg::ADDR_W-1:0]        match_address_o
);

  localparam int MaxPat = wbss_pkg::MAX_PATTERN;
  localparam int Slots  = wbss_pkg::NUM_SLOTS;
  localparam int AlenW  = wbss_pkg::ALEN_W;
  localparam int SlotW  = wbss_pkg::SLOT_W;
  localparam int AddrB  = wbss_pkg::ADDRESS_BITS;

  logic [wbss_pkg::LEN_REG_W-1:0] len_reg_q;
  logic [31:0]                    base_q;
  logic [AlenW-1:0]               len_eff, al_q, al_d;
  logic                           align_busy;
  logic [31:0]                    seen_q, seen_d, seen_inc;
  logic                           reported_q, reported_d;
  logic                           in_fire, byte_fire, idx_ok, buf_full;
  logic [SlotW-1:0]               load_slot;
  wbss_pkg::sig_ctrl_t            sig_ctrl;
  wbss_pkg::slot_t                load_entry;
  wbss_pkg::slot_t                slots [Slots];
  logic [Slots-1:0]               load_sel;
  logic [7:0]                     win_bytes [MaxPat];
  logic [MaxPat-1:0]              mismatch, active;
  logic                           match;
  logic [AddrB-1:0]               start_addr;
  logic                           res_valid;
  wbss_pkg::result_t              res, out_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q <= wbss_pkg::LEN_REG_W'(1);
      base_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wbss_pkg::REG_PATTERN_LENGTH: len_reg_q <= cfg_data_i[wbss_pkg::LEN_REG_W-1:0];
        wbss_pkg::REG_BASE_ADDRESS:   base_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_eff = wbss_pkg::eff_len(len_reg_q);

  // The signature line is aligned to one length; it steps towards a new one.
  assign align_busy = (al_q != len_eff);

  always_comb begin
    al_d = al_q;
    if (al_q < len_eff) begin
      al_d = al_q + AlenW'(1);
    end else if (al_q > len_eff) begin
      al_d = al_q - AlenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      al_q <= AlenW'(1);
    end else begin
      al_q <= al_d;
    end
  end

  // Input handshake.
  assign in_stall_o = buf_full | align_busy;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign byte_fire  = in_fire & (operation_i == wbss_pkg::OP_BYTE);
  assign idx_ok     = (int'(pattern_index_i) < MaxPat);

  // Signature entry j lives in slot al + MAX_PATTERN - 2 - j.
  assign load_slot  = SlotW'(al_q) + SlotW'(MaxPat - 2) - SlotW'(pattern_index_i);
  assign load_entry = '{care: pattern_care_i, value: pattern_byte_i};

  assign sig_ctrl.shift_up   = align_busy & (al_q < len_eff);
  assign sig_ctrl.shift_down = align_busy & (al_q > len_eff);
  assign sig_ctrl.load       = in_fire & (operation_i == wbss_pkg::OP_LOAD) & idx_ok;

  // Line of signature slots.
  for (genvar gp = 0; gp < Slots; gp++) begin : g_sig
    wbss_pkg::slot_t lower, upper;

    if (gp == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = slots[gp-1];
    end

    if (gp == Slots - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = slots[gp+1];
    end

    assign load_sel[gp] = (load_slot == SlotW'(gp));

    wbss_sig_cell u_sig_cell (
      .clk_i      (clk_i),
      .ctrl_i     (sig_ctrl),
      .load_sel_i (load_sel[gp]),
      .lower_i    (lower),
      .upper_i    (upper),
      .load_i     (load_entry),
      .slot_o     (slots[gp])
    );
  end

  // Row of window cells; cell a holds the byte of age a.
  for (genvar ga = 0; ga < MaxPat; ga++) begin : g_win
    logic [7:0] prev;

    if (ga == 0) begin : g_newest
      assign prev = data_byte_i;
    end else begin : g_older
      assign prev = win_bytes[ga-1];
    end

    assign active[ga] = (AlenW'(ga) < len_eff);

    wbss_win_cell u_win_cell (
      .clk_i      (clk_i),
      .shift_i    (byte_fire),
      .prev_i     (prev),
      .active_i   (active[ga]),
      .sig_i      (slots[MaxPat-1+ga]),
      .byte_o     (win_bytes[ga]),
      .mismatch_o (mismatch[ga])
    );
  end

  // Range state and result selection for a memory byte.
  assign seen_inc   = (seen_q == '1) ? seen_q : seen_q + 32'd1;
  assign match      = ~reported_q & (seen_inc >= 32'(len_eff)) & ~(|mismatch);
  assign start_addr = AddrB'(base_q) + AddrB'(seen_inc) - AddrB'(len_eff);

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    res_valid  = 1'b0;
    res.found  = 1'b0;
    res.addr   = '0;
    if (byte_fire) begin
      seen_d = seen_inc;
      if (match) begin
        res_valid  = 1'b1;
        res.found  = 1'b1;
        res.addr   = wbss_pkg::ADDR_W'(start_addr);
        reported_d = 1'b1;
      end else if (last_byte_i && !reported_q) begin
        res_valid = 1'b1;
      end
      if (last_byte_i) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // Result buffer.
  wbss_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign found_o         = out_res.found;
  assign match_address_o = out_res.addr;

endmodule

// File: sv/wbss_checker.sv
// Port-level checks for the signature scanner, bound to its top level.
// Depends on wbss_pkg and the assertion macro header.
`include "wildcard_byte_signature_scanner_core_assert.svh"

module wbss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           found_o,
  input logic [wbss_pkg::ADDR_W-1:0]    match_address_o
);

  // A stalled result stays offered.
  `WBSS_ASSERT_CLK(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result withdrawn while stalled")

  // A stalled result keeps its payload.
  `WBSS_ASSERT_CLK(a_out_payload_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(found_o) && $stable(match_address_o), "result changed while stalled")

  // A range that ends without a match reports address zero.
  `WBSS_ASSERT_CLK(a_not_found_zero, clk_i, rst_ni, out_valid_o && !found_o |-> match_address_o == '0, "not-found result carries an address")

  // No result is offered while reset is held; the flag may still be unknown
  // at the very first edge.
  `WBSS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> out_valid_o !== 1'b1, "result offered during reset")

endmodule

bind wildcard_byte_signature_scanner_core wbss_checker u_wbss_checker (.*);
